[design/rswtb_pkg.sv]
// ----------------------------------------------------------------------------
// rswtb_pkg: shared types and constants of the record sorter
// Record formats, capacity and state codes of the sorter modules.
// ----------------------------------------------------------------------------
package rswtb_pkg;

  localparam int MaxRecords = 64;
  localparam int PosW       = 7;
  localparam int TolW       = 31;
  localparam int QDepth     = 2;

  typedef struct packed {
    logic [15:0]        row_index;
    logic [15:0]        col_index;
    logic signed [31:0] key_value;
    logic signed [31:0] weight_value;
    logic               batch_end;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]    arrival_position;
    logic [15:0]        out_row;
    logic [15:0]        out_col;
    logic signed [31:0] out_key;
    logic signed [31:0] out_weight;
    logic [PosW-1:0]    tie_block;
    logic               overflow_flag;
    logic               run_end;
  } out_item_t;

  typedef struct packed {
    logic [PosW-1:0]    pos;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] key;
    logic signed [31:0] weight;
  } rec_t;

  typedef enum logic [1:0] {
    ST_INSERT = 2'b01,
    ST_DRAIN  = 2'b10
  } back_state_e;

endpackage

[design/rswtb_front.sv]
// ----------------------------------------------------------------------------
// rswtb_front: input queue of the record sorter
// Takes command words and buffers them for the sorting chain.
// ----------------------------------------------------------------------------
module rswtb_front import rswtb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output in_item_t q_item_o
);

  localparam int PtrW = $clog2(QDepth);

  in_item_t          mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign busy      = (cnt_q == (PtrW+1)'(QDepth));
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end

endmodule

[design/rswtb_back.sv]
// ----------------------------------------------------------------------------
// rswtb_back: insertion chain and drain of the record sorter
// Places one record per cycle into a sorted row of cells while not draining;
// on batch end shifts the row out one record per cycle with tie-block numbering.
// ----------------------------------------------------------------------------
module rswtb_back import rswtb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  in_item_t        q_item_i,
  input  logic [TolW-1:0] tol_i,
  output logic            res_strobe_o,
  output out_item_t       res_o
);

  back_state_e            state_q, state_d;
  rec_t                   cell_q [MaxRecords];
  rec_t                   cell_d [MaxRecords];
  logic [MaxRecords-1:0]  vld_q, vld_d, gt;
  logic [PosW-1:0]        cnt_q;
  logic                   ovf_q;
  logic [PosW-1:0]        blk_q, blk_nxt;
  logic signed [31:0]     prev_q;
  logic                   first_q;
  logic                   res_strobe_q;
  out_item_t              res_q;
  rec_t                   new_rec;
  logic                   take, full, last;
  logic signed [32:0]     diff;
  logic [32:0]            adiff;

  assign q_ready_o = (state_q == ST_INSERT);
  assign take      = q_valid_i && q_ready_o;
  assign full      = vld_q[MaxRecords-1];
  assign last      = !vld_q[1];

  assign new_rec.pos    = cnt_q + 1'b1;
  assign new_rec.row    = q_item_i.row_index;
  assign new_rec.col    = q_item_i.col_index;
  assign new_rec.key    = q_item_i.key_value;
  assign new_rec.weight = q_item_i.weight_value;

  // empty cells count as larger than any key; ties go behind, keeping arrival order
  always_comb begin
    for (int i = 0; i < MaxRecords; i++) begin
      gt[i] = !vld_q[i] || (cell_q[i].key > q_item_i.key_value);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxRecords; i++) begin
      cell_d[i] = cell_q[i];
      vld_d[i]  = vld_q[i];
    end
    if (state_q == ST_DRAIN) begin
      for (int i = 0; i < MaxRecords - 1; i++) begin
        cell_d[i] = cell_q[i+1];
        vld_d[i]  = vld_q[i+1];
      end
      vld_d[MaxRecords-1] = 1'b0;
    end else if (take && !full) begin
      for (int i = 0; i < MaxRecords; i++) begin
        if (gt[i]) cell_d[i] = new_rec;
      end
      // cells behind the insertion point shift up by one
      for (int i = 1; i < MaxRecords; i++) begin
        if (gt[i] && gt[i-1]) cell_d[i] = cell_q[i-1];
        vld_d[i] = vld_q[i] || vld_q[i-1];
      end
      vld_d[0] = 1'b1;
    end
  end

  always_comb begin
    diff    = {cell_q[0].key[31], cell_q[0].key} - {prev_q[31], prev_q};
    adiff   = diff[32] ? 33'(-diff) : 33'(diff);
    blk_nxt = blk_q;
    if (first_q) blk_nxt = PosW'(1);
    else if (!(adiff < {2'b00, tol_i})) blk_nxt = blk_q + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INSERT: if (take && q_item_i.batch_end) state_d = ST_DRAIN;
      ST_DRAIN:  if (last) state_d = ST_INSERT;
      default:   state_d = ST_INSERT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INSERT;
      vld_q        <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      first_q      <= 1'b1;
      blk_q        <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      vld_q        <= vld_d;
      res_strobe_q <= (state_q == ST_DRAIN);
      if (state_q == ST_DRAIN) begin
        blk_q   <= blk_nxt;
        first_q <= last;
        if (last) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end
      end else if (take) begin
        if (full) ovf_q <= 1'b1;
        else cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRecords; i++) cell_q[i] <= cell_d[i];
    if (state_q == ST_DRAIN) begin
      prev_q                 <= cell_q[0].key;
      res_q.arrival_position <= cell_q[0].pos;
      res_q.out_row          <= cell_q[0].row;
      res_q.out_col          <= cell_q[0].col;
      res_q.out_key          <= cell_q[0].key;
      res_q.out_weight       <= cell_q[0].weight;
      res_q.tie_block        <= blk_nxt;
      res_q.overflow_flag    <= ovf_q;
      res_q.run_end          <= last;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

[design/record_sort_with_tie_blocks_unit.sv]
// ----------------------------------------------------------------------------
// record_sort_with_tie_blocks_unit: stable record sorter with tie blocks
// Sorts a batch by key, numbering groups of near-equal keys.
// ----------------------------------------------------------------------------
// Insertion: one record per cycle, set by the parallel compare of the cell row,
// except while draining. Batch end: once the closing word enters the row, the
// block drains the row, registering one result per cycle, one per stored record.
// A two-word input queue keeps taking words during the drain until it fills.
// Reset clears queue, cell valid bits, counters and sets the tolerance to 1.
module record_sort_with_tie_blocks_unit import rswtb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [TolW-1:0] cfg_data_i,
  output logic            res_strobe_o,
  output out_item_t       res_o
);

  logic [TolW-1:0] tol_q;
  logic            q_valid, q_ready;
  in_item_t        q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(1);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  rswtb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  rswtb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_item_i     (q_item),
    .tol_i        (tol_q),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

[design/rswtb_checker.sv]
// ----------------------------------------------------------------------------
// rswtb_checker: port-level checks of the record sorter
// Watches the result stream for drain continuity and tie-block numbering.
// ----------------------------------------------------------------------------
module rswtb_checker import rswtb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      res_strobe_o,
  input out_item_t res_o
);

  a_drain_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.run_end |=> res_strobe_o)
    else $error("drain broke before run end");

  a_gap_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.run_end |=> !res_strobe_o)
    else $error("result right after run end");

  a_blk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.run_end |=>
      (res_o.tie_block == $past(res_o.tie_block)) ||
      (res_o.tie_block == $past(res_o.tie_block) + 7'd1))
    else $error("tie block jumped");

  a_blk_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.run_end |=> ##1 (!res_strobe_o || res_o.tie_block == 7'd1))
    else $error("new batch not starting at tie block 1");

  a_pos_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> res_o.arrival_position != '0 && res_o.tie_block != '0)
    else $error("zero position or tie block");

endmodule

bind record_sort_with_tie_blocks_unit rswtb_checker u_rswtb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

[bench/record_sort_with_tie_blocks_unit_test.sv]
// ----------------------------------------------------------------------------
// record_sort_with_tie_blocks_unit_test: self-checking bench of the sorter
// Feeds batches of records, predicts the sorted output with tie blocks and
// overflow, and compares every result word against the prediction.
// ----------------------------------------------------------------------------
module record_sort_with_tie_blocks_unit_test;
  import rswtb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 80;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  in_item_t        in_i;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [TolW-1:0] cfg_data_i;
  logic            res_strobe_o;
  out_item_t       res_o;

  record_sort_with_tie_blocks_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  in_item_t  pending_words[$];
  out_item_t sorted_expect[$];
  rec_t      batch_recs[$];
  logic [TolW-1:0] tolerance;
  logic      batch_overflow;
  int        mismatch_count;
  int        cycle_count;
  logic      calm;
  logic [TolW-1:0] cfg_pending;
  logic      cfg_req;
  logic      cfg_done;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Stable insert and emit on batch end, mirrors the block's sort.
  task automatic sort_predict(input in_item_t w);
    rec_t r;
    int p;
    int blk;
    logic signed [32:0] d;
    out_item_t o;
    if (batch_recs.size() < MaxRecords) begin
      r.pos = PosW'(batch_recs.size() + 1);
      r.row = w.row_index;
      r.col = w.col_index;
      r.key = w.key_value;
      r.weight = w.weight_value;
      p = batch_recs.size();
      while (p > 0 && batch_recs[p-1].key > w.key_value) p--;
      batch_recs.insert(p, r);
    end else begin
      batch_overflow = 1'b1;
    end
    if (w.batch_end) begin
      blk = 1;
      foreach (batch_recs[i]) begin
        if (i > 0) begin
          d = 33'(batch_recs[i].key) - 33'(batch_recs[i-1].key);
          if (d < 0) d = -d;
          if (!(d < $signed({2'b00, tolerance}))) blk++;
        end
        o.arrival_position = batch_recs[i].pos;
        o.out_row = batch_recs[i].row;
        o.out_col = batch_recs[i].col;
        o.out_key = batch_recs[i].key;
        o.out_weight = batch_recs[i].weight;
        o.tie_block = PosW'(blk);
        o.overflow_flag = batch_overflow;
        o.run_end = (i == batch_recs.size() - 1);
        sorted_expect.push_back(o);
      end
      batch_recs.delete();
      batch_overflow = 1'b0;
    end
  endtask

  // Driver: present the next word, hold it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_i <= '0;
    end else begin
      if (start && !busy) begin
        sort_predict(in_i);
        void'(pending_words.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_words.size() > 0
                   && (calm || $urandom_range(0, 99) >= 10)) begin
        in_i <= pending_words[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Configuration channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_data_i <= '0;
      cfg_done <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_valid_i <= 1'b0;
      cfg_done <= 1'b1;
    end else if (cfg_req && !cfg_done) begin
      cfg_valid_i <= 1'b1;
      cfg_data_i <= cfg_pending;
    end else if (!cfg_req) begin
      cfg_done <= 1'b0;
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && res_strobe_o) begin
      if (sorted_expect.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        out_item_t e;
        e = sorted_expect.pop_front();
        if (res_o.arrival_position !== e.arrival_position)
          report($sformatf("position %0d exp %0d", res_o.arrival_position,
                           e.arrival_position));
        if (res_o.out_row !== e.out_row)
          report($sformatf("row %0h exp %0h", res_o.out_row, e.out_row));
        if (res_o.out_col !== e.out_col)
          report($sformatf("col %0h exp %0h", res_o.out_col, e.out_col));
        if (res_o.out_key !== e.out_key)
          report($sformatf("key %0h exp %0h", res_o.out_key, e.out_key));
        if (res_o.out_weight !== e.out_weight)
          report($sformatf("weight %0h exp %0h", res_o.out_weight, e.out_weight));
        if (res_o.tie_block !== e.tie_block)
          report($sformatf("tie block %0d exp %0d", res_o.tie_block, e.tie_block));
        if (res_o.overflow_flag !== e.overflow_flag)
          report($sformatf("overflow %0b exp %0b", res_o.overflow_flag,
                           e.overflow_flag));
        if (res_o.run_end !== e.run_end)
          report($sformatf("run end %0b exp %0b", res_o.run_end, e.run_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t make_word(input logic [31:0] k, input logic last);
    in_item_t w;
    w.row_index = 16'($urandom);
    w.col_index = 16'($urandom);
    w.key_value = k;
    w.weight_value = $urandom;
    w.batch_end = last;
    return w;
  endfunction

  // Keys drawn mostly from narrow pools so ties and near ties are common.
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 6));
      2: return 32'(-$signed($urandom_range(0, 400)));
      default: return 32'h7ffffff0 + $urandom_range(0, 15);
    endcase
  endfunction

  task automatic set_tolerance(input logic [TolW-1:0] t);
    cfg_pending = t;
    cfg_req = 1'b1;
    wait (cfg_done);
    @(posedge clk_i);
    cfg_req = 1'b0;
    tolerance = t;
    @(posedge clk_i);
  endtask

  task automatic settle();
    wait (pending_words.size() == 0 && !start);
    wait (sorted_expect.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    int n;
    int total;
    int len;
    logic [TolW-1:0] tol_set[6];
    tol_set = '{31'd0, 31'h7fffffff, 31'd3, 31'h10000, 31'd100, 31'd1};
    mismatch_count = 0;
    cycle_count = 0;
    tolerance = 31'd1;
    batch_overflow = 1'b0;
    calm = 1'b0;
    cfg_req = 1'b0;
    cfg_pending = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, ties at reset tolerance, single record batch.
    pending_words.push_back(make_word(32'h7fffffff, 1'b0));
    pending_words.push_back(make_word(32'h80000000, 1'b0));
    pending_words.push_back(make_word(32'h0, 1'b0));
    pending_words.push_back(make_word(32'h0, 1'b0));
    pending_words.push_back(make_word(32'h1, 1'b0));
    pending_words.push_back(make_word(32'hffffffff, 1'b1));
    pending_words.push_back(make_word(32'h5, 1'b1));
    pending_words[0].row_index = 16'hffff;
    pending_words[0].col_index = 16'hffff;
    pending_words[0].weight_value = 32'h80000000;
    pending_words[1].row_index = 16'h0;
    pending_words[1].col_index = 16'h0;
    pending_words[1].weight_value = 32'h7fffffff;
    settle();

    // Overflow: 66 records, closing word dropped but still ends the batch.
    for (int i = 0; i < 66; i++)
      pending_words.push_back(make_word(rand_key(), i == 65));
    settle();

    total = 0;
    foreach (tol_set[t]) begin
      set_tolerance(tol_set[t]);
      calm = (t == 2);
      n = 0;
      while (n < 52) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64)
                                           : $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          pending_words.push_back(make_word(rand_key(), i == len - 1));
        n += len;
      end
      total += n;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
